FILE: sv/tpps_pkg.sv
// ----------------------------------------------------------------------------
// tpps_pkg
// Shared codes and widths for the two-pointer pair-sum block.
// ----------------------------------------------------------------------------
package tpps_pkg;

  localparam int ELEM_W   = 32;
  localparam int SUM_W    = 33;
  localparam int PDATA_W  = 64;
  localparam int PADDR_W  = 4;

  // func codes
  localparam logic [1:0] FUNC_CLEAR    = 2'd0;
  localparam logic [1:0] FUNC_APPEND_A = 2'd1;
  localparam logic [1:0] FUNC_APPEND_B = 2'd2;
  localparam logic [1:0] FUNC_RUN      = 2'd3;

  // register index (byte address / 8)
  localparam logic REG_TARGET_SUM = 1'b0;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

endpackage

FILE: sv/two_pointer_pair_sum_top.sv
// ----------------------------------------------------------------------------
// two_pointer_pair_sum_top
// Pair search over two ascending stores A and B: emits each (A[i], B[j]) met by
// the two-pointer walk (i advances on a match) whose exact sum equals target_sum, then one end marker.
// ----------------------------------------------------------------------------
// Clear and append items complete as they are accepted, and in_ready stays high
// for the next item. Each pointer step of a run passes a store read, then an
// add/compare in the shared 33-bit adder; a match or the end marker waits for
// the output to take it, and in_ready stays low until the end marker is loaded.
// Synchronous active-high reset clears counts, target_sum and the sequencer;
// store contents are not cleared.
module two_pointer_pair_sum_top #(
  parameter int DEPTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  // input channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      func,
  input  tpps_pkg::elem_t                 element_value,
  // output channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output tpps_pkg::elem_t                 value_from_a,
  output tpps_pkg::elem_t                 value_from_b,
  output logic                            is_pair,
  output logic                            last,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tpps_pkg::PADDR_W-1:0]    paddr,
  input  logic [tpps_pkg::PDATA_W-1:0]    pwdata,
  output logic [tpps_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready
);
  import tpps_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_CMP  = 2'd2;
  localparam logic [1:0] S_END  = 2'd3;

  elem_t a_mem [DEPTH];
  elem_t b_mem [DEPTH];

  logic [CW-1:0] count_a;
  logic [CW-1:0] count_b;
  sum_t          target_sum;
  logic [1:0]    state;
  logic [AW-1:0] i;
  logic [AW-1:0] j;
  elem_t         a_q;
  elem_t         b_q;

  logic in_fire;
  logic cfg_write;
  logic can_load;
  logic full_a;
  logic full_b;
  sum_t sum;
  logic gt;
  logic eq;
  logic i_last;
  logic load_pair;
  logic load_end;

  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = {{(PDATA_W-SUM_W){1'b0}}, target_sum};
  assign can_load  = !out_valid || out_ready;
  assign full_a    = (count_a == CW'(DEPTH));
  assign full_b    = (count_b == CW'(DEPTH));

  // shared adder / comparator
  assign sum    = sum_t'(a_q) + sum_t'(b_q);
  assign gt     = (sum > target_sum);
  assign eq     = (sum == target_sum);
  assign i_last = ((CW'(i) + CW'(1)) == count_a);

  assign load_pair = (state == S_CMP) && !gt && eq && can_load;
  assign load_end  = (state == S_END) && can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_sum <= '0;
    end else if (cfg_write && (paddr[3] == REG_TARGET_SUM)) begin
      target_sum <= pwdata[SUM_W-1:0];
    end
  end

  // store writes and registered reads
  always_ff @(posedge clk) begin
    if (in_fire && (func == FUNC_APPEND_A) && !full_a) begin
      a_mem[count_a[AW-1:0]] <= element_value;
    end
    if (in_fire && (func == FUNC_APPEND_B) && !full_b) begin
      b_mem[count_b[AW-1:0]] <= element_value;
    end
    if (state == S_READ) begin
      a_q <= a_mem[i];
      b_q <= b_mem[j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_a   <= '0;
      count_b   <= '0;
      state     <= S_IDLE;
      i         <= '0;
      j         <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            unique case (func)
              FUNC_CLEAR: begin
                count_a <= '0;
                count_b <= '0;
              end
              FUNC_APPEND_A: begin
                if (!full_a) count_a <= count_a + CW'(1);
              end
              FUNC_APPEND_B: begin
                if (!full_b) count_b <= count_b + CW'(1);
              end
              FUNC_RUN: begin
                i <= '0;
                j <= AW'(count_b - CW'(1));
                if ((count_a == '0) || (count_b == '0)) begin
                  state <= S_END;
                end else begin
                  state <= S_READ;
                end
              end
              default: ;
            endcase
          end
        end
        S_READ: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (gt) begin
            // B exhausted: no more pairs this run
            if (j == '0) begin
              state <= S_END;
            end else begin
              j     <= j - AW'(1);
              state <= S_READ;
            end
          end else if (!eq || can_load) begin
            if (i_last) begin
              state <= S_END;
            end else begin
              i     <= i + AW'(1);
              state <= S_READ;
            end
          end
        end
        S_END: begin
          if (can_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_pair || load_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load_pair) begin
      value_from_a <= a_q;
      value_from_b <= b_q;
      is_pair      <= 1'b1;
      last         <= 1'b0;
    end else if (load_end) begin
      value_from_a <= '0;
      value_from_b <= '0;
      is_pair      <= 1'b0;
      last         <= 1'b1;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (count_a <= CW'(DEPTH)) && (count_b <= CW'(DEPTH)))
    else $error("store count beyond depth");

  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    ((state == S_READ) || (state == S_CMP)) |->
      ((CW'(i) < count_a) && (CW'(j) < count_b)))
    else $error("run pointer outside loaded entries");

  a_pair_xor_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_pair != last))
    else $error("result is neither a single pair nor an end marker");

  a_marker_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last) |-> ((value_from_a == '0) && (value_from_b == '0)))
    else $error("end marker carries nonzero values");

  a_counts_held: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |=> ($stable(count_a) && $stable(count_b)))
    else $error("counts changed during a run");

endmodule
